// ----- design/cfp_pkg.sv -----
// Shared types, constants and helpers for the color frame parser.
package cfp_pkg;

	localparam int BYTE_W      = 8;
	localparam int ENTRY_W     = 6;
	localparam int COLOR_W     = 10;
	localparam int TYPE_W      = 3;
	localparam int SIZE_W      = 3;
	localparam int COUNT_W     = 4;
	localparam int STORE_DEPTH = 6;
	localparam int STORE_IDX_W = 3;

	localparam logic [1:0]         HDR_MARK   = 2'b11;
	localparam logic [1:0]         DATA_MARK  = 2'b00;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd8;
	localparam logic [COUNT_W-1:0] STORE_LIM  = 4'd6;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef entry_t store_t [STORE_DEPTH];

	// Parser phase, one-hot
	typedef enum logic [1:0] {
		PH_HDR  = 2'b01,
		PH_DATA = 2'b10
	} phase_t;

	// One finished frame
	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [TYPE_W-1:0]  message_type;
	} result_t;

	// Color from a high entry (2 bits used) and a low entry (6 bits)
	function automatic logic [COLOR_W-1:0] make_color(entry_t hi, entry_t lo);
		make_color = {hi[1:0], 2'b00, lo};
	endfunction

endpackage

// ----- design/color_frame_parser_unit.sv -----
// Top level of the color frame parser.
// Accepts one received word per cycle while not stalled and emits one color word
// per completed frame. A word goes through an input register and the parser
// logic into an output register. A result is loaded into the output register
// when its last data word moves on from the input register, and waits there
// until the receiver takes it. A new word can be taken every cycle. The input
// stalls only while the input register holds a word and the output register is
// full and stalled. No clearing pass after reset is needed; the six-entry payload
// store resets to zero directly.
module color_frame_parser_unit import cfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue,
	output logic [TYPE_W-1:0]  message_type
);

	logic              adv;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              res_fire;
	result_t           res;

	cfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	cfp_frame_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.byte_s1  (byte_s1),
		.res_fire (res_fire),
		.res      (res)
	);

	cfp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_fire     (res_fire),
		.res          (res),
		.valid_s1     (valid_s1),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.message_type (message_type)
	);

endmodule

// ----- design/cfp_in_stage.sv -----
// Input register stage: holds one received word until the parser takes it.
module cfp_in_stage import cfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              adv,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	// Stall only while a held word cannot move on
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ----- design/cfp_frame_fsm.sv -----
// Frame parser: header/data phase tracking, payload store and result assembly.
module cfp_frame_fsm import cfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [BYTE_W-1:0] byte_s1,
	output logic              res_fire,
	output result_t           res
);

	phase_t              phase_q, phase_n;
	logic [TYPE_W-1:0]   type_q, type_n;
	logic [SIZE_W-1:0]   size_q, size_n;
	logic [COUNT_W-1:0]  cnt_q, cnt_n;
	store_t              store_q, store_n;

	// Next state for the word at the input register
	always_comb begin
		phase_n  = phase_q;
		type_n   = type_q;
		size_n   = size_q;
		cnt_n    = cnt_q;
		store_n  = store_q;
		res_fire = 1'b0;
		case (phase_q)
			PH_HDR: begin
				if (byte_s1[7:6] == HDR_MARK) begin
					type_n  = byte_s1[5:3];
					size_n  = byte_s1[2:0];
					cnt_n   = '0;
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				if (byte_s1[7:6] != DATA_MARK) begin
					// abort, word dropped
					phase_n = PH_HDR;
				end else begin
					if (cnt_q < STORE_LIM) begin
						store_n[cnt_q[STORE_IDX_W-1:0]] = byte_s1[ENTRY_W-1:0];
					end
					if (cnt_q < COUNT_MAX) begin
						cnt_n = cnt_q + 4'd1;
					end
					if (cnt_n == {1'b0, size_q}) begin
						res_fire = 1'b1;
						phase_n  = PH_HDR;
					end
				end
			end
			default: begin
				phase_n = PH_HDR;
			end
		endcase
	end

	// Colors come from the store including this word
	assign res.red          = make_color(store_n[0], store_n[1]);
	assign res.green        = make_color(store_n[2], store_n[3]);
	assign res.blue         = make_color(store_n[4], store_n[5]);
	assign res.message_type = type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			type_q  <= '0;
			size_q  <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (adv) begin
			phase_q <= phase_n;
			type_q  <= type_n;
			size_q  <= size_n;
			cnt_q   <= cnt_n;
			store_q <= store_n;
		end
	end

endmodule

// ----- design/cfp_out_stage.sv -----
// Output register: holds a finished frame until the receiver takes it.
module cfp_out_stage import cfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_fire,
	input  result_t            res,
	input  logic               valid_s1,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue,
	output logic [TYPE_W-1:0]  message_type
);

	logic    out_free;
	result_t res_q;

	// Register can load when empty or being taken this cycle
	assign out_free = !out_valid || !out_stall;
	assign adv      = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= adv && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_fire) begin
			res_q <= res;
		end
	end

	assign red          = res_q.red;
	assign green        = res_q.green;
	assign blue         = res_q.blue;
	assign message_type = res_q.message_type;

endmodule

// ----- design/cfp_checker.sv -----
// Port-level checker for the color frame parser, bound to the top level.
module cfp_checker import cfp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [BYTE_W-1:0]  rx_byte,
	input logic               out_valid,
	input logic               out_stall,
	input logic [COLOR_W-1:0] red,
	input logic [COLOR_W-1:0] green,
	input logic [COLOR_W-1:0] blue,
	input logic [TYPE_W-1:0]  message_type
);

	// A stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input word changed");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(message_type))
		else $error("stalled result changed");

	// Input backs up only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// A fresh result follows an earlier accepted word
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without accepted word");

endmodule

bind color_frame_parser_unit cfp_checker u_cfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.rx_byte      (rx_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.red          (red),
	.green        (green),
	.blue         (blue),
	.message_type (message_type)
);

// ----- dv/tb_color_frame_parser_unit.sv -----
// Self-checking testbench for the color frame parser: directed and random byte streams.
module tb_color_frame_parser_unit;
	import cfp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 340;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic [TYPE_W-1:0]  message_type;

	// Stimulus and expectations
	logic [BYTE_W-1:0] byte_q[$];
	result_t           color_q[$];
	result_t           want;
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                errors = 0;
	int                cycles = 0;
	logic              word_taken = 1'b0;
	logic              hold_go = 1'b0;
	logic              hold_seen = 1'b0;
	int                hold_left = 0;

	// Parser state as the testbench sees it
	logic               in_frame = 1'b0;
	logic [TYPE_W-1:0]  frame_type = '0;
	logic [SIZE_W-1:0]  frame_size = '0;
	logic [COUNT_W-1:0] data_count = '0;
	logic [ENTRY_W-1:0] payload [STORE_DEPTH] = '{default: '0};

	color_frame_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.message_type (message_type)
	);

	always #2 clk = ~clk;

	// Two low bits of the high entry land at 9:8, low entry at 5:0
	function automatic logic [COLOR_W-1:0] pair_color(logic [ENTRY_W-1:0] hi,
			logic [ENTRY_W-1:0] lo);
		logic [COLOR_W-1:0] c;
		c = COLOR_W'(lo);
		c[9:8] = hi[1:0];
		return c;
	endfunction

	// Advance the parser by one accepted word; queue a color word on frame end
	task automatic parse_byte(logic [BYTE_W-1:0] b);
		result_t r;
		if (!in_frame) begin
			if (b[7:6] == HDR_MARK) begin
				frame_type = b[5:3];
				frame_size = b[2:0];
				data_count = '0;
				in_frame = 1'b1;
			end
		end else if (b[7:6] != DATA_MARK) begin
			// abort, the word itself is dropped
			in_frame = 1'b0;
		end else begin
			if (data_count < STORE_DEPTH)
				payload[data_count[STORE_IDX_W-1:0]] = b[5:0];
			if (data_count < COUNT_MAX)
				data_count = data_count + COUNT_W'(1);
			if (data_count == COUNT_W'(frame_size)) begin
				r.red = pair_color(payload[0], payload[1]);
				r.green = pair_color(payload[2], payload[3]);
				r.blue = pair_color(payload[4], payload[5]);
				r.message_type = frame_type;
				color_q.push_back(r);
				in_frame = 1'b0;
			end
		end
	endtask

	task automatic compare(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
			errors++;
		end
	endtask

	// Random frames: mostly well formed, some aborted, some junk between frames
	task automatic queue_frames(int target);
		int made;
		int ndata;
		bit aborted;
		logic [1:0] top;
		logic [TYPE_W-1:0] ftype;
		logic [SIZE_W-1:0] fsize;
		logic [ENTRY_W-1:0] low;
		made = 0;
		while (made < target) begin
			if ($urandom_range(99) < 8) begin
				// ignored while hunting for a header
				top = 2'($urandom_range(2));
				low = ENTRY_W'($urandom);
				byte_q.push_back({top, low});
			end else begin
				ftype = TYPE_W'($urandom_range(7));
				fsize = ($urandom_range(99) < 6) ? '0 : SIZE_W'($urandom_range(1, 7));
				byte_q.push_back({HDR_MARK, ftype, fsize});
				made++;
				if (fsize == 0) begin
					// never completes; long runs push the count into saturation
					aborted = 1'b1;
					ndata = $urandom_range(12);
				end else begin
					aborted = ($urandom_range(99) < 10);
					ndata = aborted ? $urandom_range(int'(fsize) - 1) : int'(fsize);
				end
				for (int i = 0; i < ndata; i++) begin
					low = ENTRY_W'($urandom);
					byte_q.push_back({DATA_MARK, low});
					made++;
				end
				if (aborted) begin
					top = 2'($urandom_range(1, 3));
					low = ENTRY_W'($urandom);
					byte_q.push_back({top, low});
					made++;
				end
			end
		end
	endtask

	// Wait until every queued word is taken and every color word has come
	task automatic drain();
		while (byte_q.size() != 0 || in_valid)
			@(negedge clk);
		while (color_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle, int stall, int words);
		idle_pct = idle;
		stall_pct = stall;
		queue_frames(words);
		drain();
		repeat ($urandom_range(1, 20)) @(negedge clk);
	endtask

	// Sender: offer the next word, hold it while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !word_taken) begin
			in_valid <= 1'b1;
		end else if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
			in_valid <= 1'b1;
			rx_byte <= byte_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Input side: predict on every accepted word
	always @(posedge clk) begin
		word_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			parse_byte(rx_byte);
	end

	// Output side: compare each accepted color word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (color_q.size() == 0) begin
				$display("%0t: unexpected color word, expected none, got %0d %0d %0d type %0d",
					$time, red, green, blue, message_type);
				errors++;
			end else begin
				want = color_q.pop_front();
				compare("red", int'(want.red), int'(red));
				compare("green", int'(want.green), int'(green));
				compare("blue", int'(want.blue), int'(blue));
				compare("message_type", int'(want.message_type), int'(message_type));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: junk before any header, a full frame, a short frame reusing
		// old payload, a size-7 frame past the store, a size-0 frame aborted by
		// a header-looking word
		byte_q = {8'h80, 8'h3F,
			8'hFE, 8'h3F, 8'h00, 8'h2A, 8'h15, 8'h3F, 8'h3F,
			8'hC1, 8'h03,
			8'hC7, 8'h01, 8'h3E, 8'h02, 8'h3D, 8'h33, 8'h0C, 8'h3F,
			8'hC0, 8'h3F, 8'h3F, 8'h3F, 8'hD5};
		drain();

		run_phase(0, 0, PHASE_WORDS);
		run_phase(55, 0, PHASE_WORDS);
		run_phase(0, 55, PHASE_WORDS);
		run_phase(11, 11, PHASE_WORDS);

		// Back pressure: long receiver hold while the sender keeps offering
		idle_pct = 0;
		stall_pct = 0;
		queue_frames(PHASE_WORDS);
		hold_go <= ~hold_go;
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/cfp_pkg.sv
design/cfp_in_stage.sv
design/cfp_frame_fsm.sv
design/cfp_out_stage.sv
design/color_frame_parser_unit.sv
design/cfp_checker.sv
dv/tb_color_frame_parser_unit.sv
